// ----- rtl/sled_pkg.sv -----
package sled_pkg;

	// Command word: opcode in the top bit, new state below
	typedef struct packed {
		logic       opcode;
		logic [2:0] new_state;
	} cmd_item_t;

	// Frame word
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [8:0] hold_ms;
	} frame_item_t;

	localparam int unsigned RECIP_W = 20;
	localparam int unsigned RECIP_SHIFT = 19;
	// ceil(2^19 / 100): exact floor(x / 100) for x below 2^15
	localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5243);
	// Reciprocal product for the reset brightness of 100 percent
	localparam logic [RECIP_W-1:0] RECIP_RESET = RECIP_W'(100 * RECIP_100);

	// Configuration as held; brightness is kept as its scaled reciprocal product
	typedef struct packed {
		logic [RECIP_W-1:0] bright_recip;
		logic               led_enabled;
		logic [23:0]        boot_rgb;
		logic [23:0]        fault_rgb;
		logic [23:0]        adv_rgb;
		logic [23:0]        link_rgb;
		logic [23:0]        secure_rgb;
		logic [23:0]        idle_rgb;
		logic [23:0]        flash_rgb;
	} cfg_t;

	localparam logic [2:0] CFG_BRIGHTNESS  = 3'd0;
	localparam logic [2:0] CFG_ENABLE      = 3'd1;
	localparam logic [2:0] CFG_BOOT_ERROR  = 3'd2;
	localparam logic [2:0] CFG_ADVERTISING = 3'd3;
	localparam logic [2:0] CFG_CONNECTED   = 3'd4;
	localparam logic [2:0] CFG_SECURED     = 3'd5;
	localparam logic [2:0] CFG_READY       = 3'd6;
	localparam logic [2:0] CFG_ACTIVITY    = 3'd7;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_SET  = 1'b1;

	localparam logic [2:0] ST_BOOT        = 3'd0;
	localparam logic [2:0] ST_ADVERTISING = 3'd1;
	localparam logic [2:0] ST_CONNECTED   = 3'd2;
	localparam logic [2:0] ST_SECURED     = 3'd3;
	localparam logic [2:0] ST_READY       = 3'd4;
	localparam logic [2:0] ST_ACTIVITY    = 3'd5;
	localparam logic [2:0] ST_ERROR       = 3'd6;

	localparam logic [7:0] SWEEP_LEVEL   = 8'd128;
	localparam logic [8:0] SWEEP_HOLD    = 9'd300;
	localparam logic [8:0] OFF_HOLD      = 9'd120;
	localparam logic [8:0] ACTIVITY_HOLD = 9'd100;
	localparam logic [8:0] STATE_HOLD    = 9'd250;
	localparam logic [6:0] PHASE_LAST    = 7'd119;
	localparam logic [2:0] PHASE6_LAST   = 3'd5;
	localparam logic [4:0] PHASE20_LAST  = 5'd19;
	localparam logic [1:0] ACTIVITY_FRAMES = 2'd2;
	localparam logic [2:0] SWEEP_STEPS   = 3'd4;

endpackage

// ----- rtl/sled_cfg_regs.sv -----
module sled_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [47:0]        cfg_data,
	output sled_pkg::cfg_t     cfg
);

	sled_pkg::cfg_t                 cfg_q;
	logic [sled_pkg::RECIP_W-1:0]   bright_ext;
	logic [sled_pkg::RECIP_W-1:0]   recip_d;

	// Brightness times the reciprocal of 100, worked out once per write
	assign bright_ext = {{(sled_pkg::RECIP_W - 7){1'b0}}, cfg_data[6:0]};
	assign recip_d    = bright_ext * sled_pkg::RECIP_100;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bright_recip <= sled_pkg::RECIP_RESET;
			cfg_q.led_enabled  <= 1'b1;
			cfg_q.boot_rgb     <= '0;
			cfg_q.fault_rgb    <= '0;
			cfg_q.adv_rgb      <= '0;
			cfg_q.link_rgb     <= '0;
			cfg_q.secure_rgb   <= '0;
			cfg_q.idle_rgb     <= '0;
			cfg_q.flash_rgb    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sled_pkg::CFG_BRIGHTNESS:  cfg_q.bright_recip <= recip_d;
				sled_pkg::CFG_ENABLE:      cfg_q.led_enabled <= cfg_data[0];
				sled_pkg::CFG_BOOT_ERROR: begin
					cfg_q.boot_rgb  <= cfg_data[47:24];
					cfg_q.fault_rgb <= cfg_data[23:0];
				end
				sled_pkg::CFG_ADVERTISING: cfg_q.adv_rgb <= cfg_data[23:0];
				sled_pkg::CFG_CONNECTED:   cfg_q.link_rgb <= cfg_data[23:0];
				sled_pkg::CFG_SECURED:     cfg_q.secure_rgb <= cfg_data[23:0];
				sled_pkg::CFG_READY:       cfg_q.idle_rgb <= cfg_data[23:0];
				sled_pkg::CFG_ACTIVITY:    cfg_q.flash_rgb <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/sled_scale.sv -----
module sled_scale (
	input  logic [7:0]                    level,
	input  logic [sled_pkg::RECIP_W-1:0]  bright_recip,
	output logic [7:0]                    scaled
);

	logic [sled_pkg::RECIP_W+7:0] prod;
	logic [8:0]                   quot;

	// level * brightness / 100 via the reciprocal product, then saturate
	assign prod = {{sled_pkg::RECIP_W{1'b0}}, level} * {8'd0, bright_recip};
	assign quot = prod[sled_pkg::RECIP_W+7:sled_pkg::RECIP_SHIFT];
	assign scaled = quot[8] ? 8'hff : quot[7:0];

endmodule

// ----- rtl/sled_frame_gen.sv -----
module sled_frame_gen (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sled_pkg::cfg_t        cfg,
	input  sled_pkg::cmd_item_t   cmd_s1,
	input  logic                  fire,
	output sled_pkg::frame_item_t frame_d
);

	logic [2:0] startup_step_q;
	logic [6:0] tick_phase_q;
	logic [2:0] phase6_q;
	logic [4:0] phase20_q;
	logic [2:0] display_state_q;
	logic [1:0] activity_left_q;

	logic        is_tick;
	logic        sweeping;
	logic        activity_frame;
	logic        pattern_on;
	logic [23:0] state_rgb;
	logic [23:0] shown_color;
	logic [7:0]  red_sc, green_sc, blue_sc;
	sled_pkg::frame_item_t raw;

	assign is_tick        = (cmd_s1.opcode == sled_pkg::OP_TICK);
	assign sweeping       = (startup_step_q < sled_pkg::SWEEP_STEPS);
	assign activity_frame = (activity_left_q != 2'd0);

	always_comb begin
		case (display_state_q)
			sled_pkg::ST_BOOT:        state_rgb = cfg.boot_rgb;
			sled_pkg::ST_ADVERTISING: state_rgb = cfg.adv_rgb;
			sled_pkg::ST_CONNECTED:   state_rgb = cfg.link_rgb;
			sled_pkg::ST_SECURED:     state_rgb = cfg.secure_rgb;
			sled_pkg::ST_READY:       state_rgb = cfg.idle_rgb;
			sled_pkg::ST_ACTIVITY:    state_rgb = cfg.flash_rgb;
			default:                  state_rgb = cfg.fault_rgb;
		endcase
	end

	// Blink patterns; mod 6 and mod 20 come from their own phase counters
	always_comb begin
		case (display_state_q)
			sled_pkg::ST_BOOT:        pattern_on = !tick_phase_q[0];
			sled_pkg::ST_ADVERTISING: pattern_on = !tick_phase_q[1];
			sled_pkg::ST_CONNECTED:   pattern_on = (phase6_q < 3'd3);
			sled_pkg::ST_SECURED:     pattern_on = !(tick_phase_q[2] && tick_phase_q[1]);
			sled_pkg::ST_READY:       pattern_on = (phase20_q != 5'd0);
			sled_pkg::ST_ERROR:       pattern_on = !tick_phase_q[0];
			default:                  pattern_on = 1'b1;
		endcase
	end

	assign shown_color = activity_frame ? cfg.flash_rgb : state_rgb;

	sled_scale u_scale_r (.level(shown_color[23:16]), .bright_recip(cfg.bright_recip),
		.scaled(red_sc));
	sled_scale u_scale_g (.level(shown_color[15:8]), .bright_recip(cfg.bright_recip),
		.scaled(green_sc));
	sled_scale u_scale_b (.level(shown_color[7:0]), .bright_recip(cfg.bright_recip),
		.scaled(blue_sc));

	always_comb begin
		raw = '0;
		if (sweeping) begin
			case (startup_step_q)
				3'd0: begin
					raw.red     = sled_pkg::SWEEP_LEVEL;
					raw.hold_ms = sled_pkg::SWEEP_HOLD;
				end
				3'd1: begin
					raw.green   = sled_pkg::SWEEP_LEVEL;
					raw.hold_ms = sled_pkg::SWEEP_HOLD;
				end
				3'd2: begin
					raw.blue    = sled_pkg::SWEEP_LEVEL;
					raw.hold_ms = sled_pkg::SWEEP_HOLD;
				end
				default: raw.hold_ms = sled_pkg::OFF_HOLD;
			endcase
		end else if (activity_frame || pattern_on) begin
			raw.red     = red_sc;
			raw.green   = green_sc;
			raw.blue    = blue_sc;
			raw.hold_ms = activity_frame ? sled_pkg::ACTIVITY_HOLD : sled_pkg::STATE_HOLD;
		end else begin
			raw.hold_ms = sled_pkg::STATE_HOLD;
		end
		frame_d = raw;
		if (!cfg.led_enabled) begin
			frame_d.red   = '0;
			frame_d.green = '0;
			frame_d.blue  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			startup_step_q  <= '0;
			tick_phase_q    <= '0;
			phase6_q        <= '0;
			phase20_q       <= '0;
			display_state_q <= sled_pkg::ST_BOOT;
			activity_left_q <= '0;
		end else if (fire) begin
			if (!is_tick) begin
				if (cmd_s1.new_state == sled_pkg::ST_ACTIVITY)
					activity_left_q <= sled_pkg::ACTIVITY_FRAMES;
				else
					display_state_q <= cmd_s1.new_state;
			end else if (sweeping) begin
				startup_step_q <= startup_step_q + 3'd1;
			end else begin
				if (activity_frame)
					activity_left_q <= activity_left_q - 2'd1;
				tick_phase_q <= (tick_phase_q == sled_pkg::PHASE_LAST) ? 7'd0
					: tick_phase_q + 7'd1;
				phase6_q <= (phase6_q == sled_pkg::PHASE6_LAST) ? 3'd0 : phase6_q + 3'd1;
				phase20_q <= (phase20_q == sled_pkg::PHASE20_LAST) ? 5'd0
					: phase20_q + 5'd1;
			end
		end
	end

endmodule

// ----- rtl/status_led_pattern_generator_core.sv -----
// Channel   Direction  Handshake               Word
// cmd       in         cmd_valid / cmd_stall   sled_pkg::cmd_item_t
// frame     out        frame_valid / frame_stall  sled_pkg::frame_item_t
// cfg       in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One command word is taken every cycle while cmd_stall is low; a tick passes
// through the input register, then the frame register. Throughput is set by the
// frame register alone: a tick waits in the input register only while a frame is
// stalled. Set-state words never wait, as they give no frame.
// Reset is asynchronous, active low, and leaves the block ready at once.
// cfg_ready is always high.
module status_led_pattern_generator_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  sled_pkg::cmd_item_t   cmd,
	output logic                  frame_valid,
	input  logic                  frame_stall,
	output sled_pkg::frame_item_t frame,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [47:0]           cfg_data
);

	sled_pkg::cfg_t        cfg;
	sled_pkg::cmd_item_t   cmd_s1;
	logic                  valid_s1;
	sled_pkg::frame_item_t frame_d;
	sled_pkg::frame_item_t frame_s2;
	logic                  frame_valid_s2;
	logic                  tick_s1;
	logic                  fire_s1;

	assign cfg_ready = 1'b1;

	sled_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// A held tick may leave the input register only if the frame register
	// is empty or drains this cycle; set words always leave.
	assign tick_s1 = (cmd_s1.opcode == sled_pkg::OP_TICK);
	assign fire_s1 = valid_s1 && (!tick_s1 || !frame_valid_s2 || !frame_stall);
	assign cmd_stall = valid_s1 && !fire_s1;

	// Input register: load whenever not stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!cmd_stall)
			valid_s1 <= cmd_valid;
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall)
			cmd_s1 <= cmd;
	end

	sled_frame_gen u_gen (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cmd_s1  (cmd_s1),
		.fire    (fire_s1),
		.frame_d (frame_d)
	);

	// Frame register: fill on a ticking word, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			frame_valid_s2 <= 1'b0;
		else if (fire_s1 && tick_s1)
			frame_valid_s2 <= 1'b1;
		else if (!frame_stall)
			frame_valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && tick_s1)
			frame_s2 <= frame_d;
	end

	assign frame_valid = frame_valid_s2;
	assign frame       = frame_s2;

`ifndef SYNTHESIS
	a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> (frame_valid && frame_stall))
		else $error("command stalled with frame register free");

	a_hold_legal: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid |-> (frame.hold_ms == sled_pkg::SWEEP_HOLD
			|| frame.hold_ms == sled_pkg::OFF_HOLD
			|| frame.hold_ms == sled_pkg::ACTIVITY_HOLD
			|| frame.hold_ms == sled_pkg::STATE_HOLD))
		else $error("frame hold time out of set");

	a_set_no_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && !tick_s1 && !frame_valid) |=> !frame_valid)
		else $error("set word produced a frame");
`endif

endmodule
